// ----- rtl/pte_pkg.sv -----
// ----------------------------------------------------------------------------
// pte_pkg
// Shared constants and types for the prefix tree engine.
// ----------------------------------------------------------------------------
package pte_pkg;

	// default sizing
	localparam int NODE_COUNT_DEF  = 256;
	localparam int SYMBOL_BITS_DEF = 8;

	// operation codes carried with each word
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_PREFIX = 2'd2;

	// strobes from the walk control to the node store
	typedef struct packed {
		logic child_rd;
		logic child_wr;
		logic end_rd;
		logic end_wr;
	} store_ctl_t;

endpackage

// ----- rtl/pte_node_store.sv -----
// ----------------------------------------------------------------------------
// pte_node_store
// Child table and end-of-word marks, registered synchronous read.
// ----------------------------------------------------------------------------
module pte_node_store #(
	parameter int NODE_COUNT  = pte_pkg::NODE_COUNT_DEF,
	parameter int SYMBOL_BITS = pte_pkg::SYMBOL_BITS_DEF
) (
	input  logic                                      clk,
	input  pte_pkg::store_ctl_t                       ctl,
	input  logic [$clog2(NODE_COUNT)+SYMBOL_BITS-1:0] child_addr,
	input  logic [$clog2(NODE_COUNT)-1:0]             child_wdata,
	output logic [$clog2(NODE_COUNT)-1:0]             child_rdata,
	input  logic [$clog2(NODE_COUNT)-1:0]             end_addr,
	input  logic                                      end_wdata,
	output logic                                      end_rdata
);

	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int SLOT_COUNT = NODE_COUNT << SYMBOL_BITS;

	logic [NODE_BITS-1:0] child_mem [SLOT_COUNT];
	logic                 end_mem   [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.child_wr) begin
			child_mem[child_addr] <= child_wdata;
		end
		if (ctl.child_rd) begin
			child_rdata <= child_mem[child_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.end_wr) begin
			end_mem[end_addr] <= end_wdata;
		end
		if (ctl.end_rd) begin
			end_rdata <= end_mem[end_addr];
		end
	end

endmodule

// ----- rtl/prefix_tree_engine_core.sv -----
// ----------------------------------------------------------------------------
// prefix_tree_engine_core
// Prefix tree (trie) engine: insert, exact search and prefix test.
// ----------------------------------------------------------------------------
// Words arrive one symbol per input word, the last one flagged by s_tlast;
// exactly one result word (answer, table_full) comes out for each last input.
// An input word with a symbol steps through the walk state while the walk is
// still on the tree: the child of the current node is read from the child
// table (registered synchronous RAM read) before the next symbol's address is
// known. Once the walk has stalled, a symbol is skipped and its word is taken
// in the idle state alone. A last input word adds the finish state for the
// end-mark RAM read. A word without a symbol and without last is taken in the idle state alone.
// The result sits in an output register, so the next word is taken while a
// result still waits; the engine only holds back a finished word when that
// register is still occupied. After reset both tables are cleared by a sweep
// over all NODE_COUNT * 2**SYMBOL_BITS child slots (65536 at the defaults),
// during which s_tready stays low. Nodes come from a counter and are never
// freed; once it reaches NODE_COUNT an insert that needs a new node reports
// table_full and leaves the word unmarked.
// ----------------------------------------------------------------------------
module prefix_tree_engine_core #(
	parameter int NODE_COUNT  = pte_pkg::NODE_COUNT_DEF,
	parameter int SYMBOL_BITS = pte_pkg::SYMBOL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] mode, [9:2] symbol, [10] has_symbol
	input  logic        s_tlast,   // last
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] answer, [1] table_full
);

	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int SLOT_BITS  = NODE_BITS + SYMBOL_BITS;
	localparam int SLOT_COUNT = NODE_COUNT << SYMBOL_BITS;
	localparam logic [SLOT_BITS-1:0] SLOT_LAST  = SLOT_BITS'(SLOT_COUNT - 1);
	localparam logic [NODE_BITS:0]   NODE_LIMIT = (NODE_BITS+1)'(NODE_COUNT);

	typedef enum logic [1:0] {
		ST_CLEAR,   // post-reset sweep of both tables
		ST_IDLE,    // waiting for an input word
		ST_WALK,    // child read data valid, step the walk
		ST_FINISH   // end mark read data valid, build the result
	} state_t;

	state_t                 state_q;
	logic [SLOT_BITS-1:0]   clr_q;
	logic [1:0]             mode_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   last_q;
	logic [NODE_BITS-1:0]   cur_q;       // node reached so far
	logic                   missing_q;   // search/prefix fell off the tree
	logic                   overflow_q;  // insert ran out of nodes
	logic [NODE_BITS:0]     free_q;      // next node to hand out
	logic                   out_valid_q;
	logic [1:0]             out_data_q;

	// input word fields
	logic [1:0]             in_mode;
	logic [SYMBOL_BITS-1:0] in_sym;
	logic                   in_has;
	logic                   accept;
	logic                   stalled;
	logic                   out_free;

	// store interface
	pte_pkg::store_ctl_t    ctl;
	logic [SLOT_BITS-1:0]   child_addr;
	logic [NODE_BITS-1:0]   child_wdata;
	logic [NODE_BITS-1:0]   child_rdata;
	logic [NODE_BITS-1:0]   end_addr;
	logic                   end_wdata;
	logic                   end_rdata;

	// walk step
	logic                   hit;
	logic                   alloc;
	logic [NODE_BITS-1:0]   next_cur;
	logic                   next_missing;
	logic                   next_overflow;

	// result
	logic                   res_answer;
	logic                   res_full;

	assign in_mode  = s_tdata[1:0];
	assign in_sym   = s_tdata[2 +: SYMBOL_BITS];   // upper symbol bits ignored
	assign in_has   = s_tdata[10];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign stalled  = missing_q || overflow_q;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q};

	// one step down the tree; a zero child means no edge (root is never a child)
	always_comb begin
		hit           = (child_rdata != '0);
		alloc         = 1'b0;
		next_cur      = cur_q;
		next_missing  = missing_q;
		next_overflow = overflow_q;
		if (hit) begin
			next_cur = child_rdata;
		end else if (mode_q == pte_pkg::MODE_INSERT) begin
			if (free_q < NODE_LIMIT) begin
				alloc    = 1'b1;
				next_cur = free_q[NODE_BITS-1:0];
			end else begin
				next_overflow = 1'b1;
			end
		end else begin
			next_missing = 1'b1;
		end
	end

	// result of the word; the last word's mode decides, unused code acts as prefix
	always_comb begin
		res_answer = !stalled;
		res_full   = 1'b0;
		unique case (mode_q)
			pte_pkg::MODE_INSERT: begin
				res_full = overflow_q;
			end
			pte_pkg::MODE_SEARCH: begin
				res_answer = !stalled && end_rdata;
			end
			default: begin
				res_answer = !stalled;
			end
		endcase
	end

	// store strobes and addresses
	always_comb begin
		ctl          = '0;
		child_addr   = {cur_q, sym_q};
		child_wdata  = free_q[NODE_BITS-1:0];
		end_addr     = cur_q;
		end_wdata    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.child_wr = 1'b1;
				ctl.end_wr   = 1'b1;
				child_addr   = clr_q;
				child_wdata  = '0;
				end_addr     = clr_q[SLOT_BITS-1:SYMBOL_BITS];
				end_wdata    = 1'b0;
			end
			ST_IDLE: begin
				child_addr   = {cur_q, in_sym};
				ctl.child_rd = accept && in_has && !stalled;
				ctl.end_rd   = accept && !(in_has && !stalled) && s_tlast;
			end
			ST_WALK: begin
				ctl.child_wr = alloc;
				ctl.end_rd   = last_q;
				end_addr     = next_cur;
			end
			ST_FINISH: begin
				ctl.end_wr   = out_free && (mode_q == pte_pkg::MODE_INSERT) && !stalled;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	pte_node_store #(
		.NODE_COUNT  (NODE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_store (
		.clk         (clk),
		.ctl         (ctl),
		.child_addr  (child_addr),
		.child_wdata (child_wdata),
		.child_rdata (child_rdata),
		.end_addr    (end_addr),
		.end_wdata   (end_wdata),
		.end_rdata   (end_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mode_q      <= pte_pkg::MODE_INSERT;
			sym_q       <= '0;
			last_q      <= 1'b0;
			cur_q       <= '0;
			missing_q   <= 1'b0;
			overflow_q  <= 1'b0;
			free_q      <= (NODE_BITS+1)'(1);
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// a finish step in this cycle reloads the register itself
			if (out_valid_q && m_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						mode_q <= in_mode;
						sym_q  <= in_sym;
						last_q <= s_tlast;
						if (in_has && !stalled) begin
							state_q <= ST_WALK;
						end else if (s_tlast) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					cur_q      <= next_cur;
					missing_q  <= next_missing;
					overflow_q <= next_overflow;
					if (alloc) begin
						free_q <= free_q + 1'b1;
					end
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {res_full, res_answer};
						cur_q       <= '0;
						missing_q   <= 1'b0;
						overflow_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// allocation counter never runs past the table
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NODE_LIMIT)
		else $error("node counter past table size");

	// the walk only ever stands on an allocated node
	a_cur_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_q} < free_q)
		else $error("walk on unallocated node");

	// a child is written during a walk only for an insert that found no edge
	a_alloc_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && ctl.child_wr) |->
			(child_rdata == '0 && mode_q == pte_pkg::MODE_INSERT))
		else $error("child written over an existing edge");

	// a result appears only out of the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result without a finished word");

endmodule
